// File: hdl/dtie_pkg.sv
// Shared types and constants for the double to IEEE format encoder.
`default_nettype none
package dtie_pkg;

   localparam int unsigned DataWidth = 64;

   typedef enum logic [1:0] {
      FMT_HALF   = 2'd0,
      FMT_SINGLE = 2'd1,
      FMT_DOUBLE = 2'd2,
      FMT_ALT    = 2'd3
   } fmt_type;

   typedef enum logic [1:0] {
      CLS_FINITE = 2'd0,
      CLS_ZERO   = 2'd1,
      CLS_INF    = 2'd2,
      CLS_NAN    = 2'd3
   } class_type;

   // stage 1 -> stage 2: classified operand with its leading-one position
   typedef struct packed {
      logic        sign;
      class_type   cls;
      logic [1:0]  fmt;
      logic [5:0]  lead;
      logic        sub;
      logic [10:0] exp;
      logic [51:0] frac;
   } norm_type;

   // stage 2 -> stage 3: biased target exponent and aligned significand
   typedef struct packed {
      logic        sign;
      class_type   cls;
      logic [1:0]  fmt;
      logic        ovf;
      logic        unf;
      logic [6:0]  shift;
      logic [11:0] biased;
      logic [52:0] sig;
   } align_type;

endpackage : dtie_pkg
`default_nettype wire

// File: hdl/dtie_classify.sv
// Stage 1: split and classify the operand, find the leading one of subnormals.
`default_nettype none
module dtie_classify (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     advance,
   input  wire logic                     in_valid,
   input  wire logic [63:0]              in_bits,
   input  wire logic [1:0]               fmt,
   output logic                          out_valid,
   output dtie_pkg::norm_type            out_data
);

   logic               valid_ff;
   dtie_pkg::norm_type data_ff, data_in;
   logic [10:0]        e;
   logic [51:0]        f;
   logic [5:0]         p;

   assign e = in_bits[62:52];
   assign f = in_bits[51:0];

   always_comb begin
      p = 6'd0;
      for (int i = 1; i < 52; i++) begin
         if (f[i]) begin
            p = 6'(i);
         end
      end
   end

   always_comb begin
      data_in.sign = in_bits[63];
      data_in.fmt  = fmt;
      data_in.lead = p;
      data_in.sub  = (e == 11'd0);
      data_in.exp  = e;
      data_in.frac = f;
      if (e == 11'h7FF) begin
         data_in.cls = (f != 52'd0) ? dtie_pkg::CLS_NAN : dtie_pkg::CLS_INF;
      end else if (e == 11'd0 && f == 52'd0) begin
         data_in.cls = dtie_pkg::CLS_ZERO;
      end else begin
         data_in.cls = dtie_pkg::CLS_FINITE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule : dtie_classify
`default_nettype wire

// File: hdl/dtie_align.sv
// Stage 2: normalize the significand and rebias the exponent for the target.
`default_nettype none
module dtie_align (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     advance,
   input  wire logic                     in_valid,
   input  wire dtie_pkg::norm_type       in_data,
   output logic                          out_valid,
   output dtie_pkg::align_type           out_data
);

   logic                valid_ff;
   dtie_pkg::align_type data_ff, data_in;
   logic signed [12:0]  unbiased;
   logic signed [12:0]  biased;
   logic signed [12:0]  bias;
   logic signed [12:0]  max_exp;
   logic signed [12:0]  sh;
   logic [5:0]          mbits;
   logic [52:0]         m;

   always_comb begin
      case (in_data.fmt)
         dtie_pkg::FMT_HALF: begin
            bias = 13'sd15; max_exp = 13'sd31; mbits = 6'd10;
         end
         dtie_pkg::FMT_DOUBLE: begin
            bias = 13'sd1023; max_exp = 13'sd2047; mbits = 6'd52;
         end
         default: begin
            bias = 13'sd127; max_exp = 13'sd255; mbits = 6'd23;
         end
      endcase
      if (in_data.sub) begin
         unbiased = 13'(signed'({7'd0, in_data.lead})) - 13'sd1074;
         m = 53'({1'b0, in_data.frac} << (6'd52 - in_data.lead));
      end else begin
         unbiased = 13'(signed'({2'd0, in_data.exp})) - 13'sd1023;
         m = {1'b1, in_data.frac};
      end
      biased = unbiased + bias;
      sh = 13'sd53 - 13'(signed'({7'd0, mbits})) - biased;
      data_in.sign   = in_data.sign;
      data_in.cls    = in_data.cls;
      data_in.fmt    = in_data.fmt;
      data_in.ovf    = (biased >= max_exp);
      data_in.unf    = (biased <= 13'sd0);
      data_in.shift  = (sh >= 13'sd64) ? 7'd64 : 7'(sh);
      data_in.biased = biased[11:0];
      data_in.sig    = m;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule : dtie_align
`default_nettype wire

// File: hdl/dtie_pack.sv
// Stage 3: shift the mantissa into place and assemble the result pattern.
`default_nettype none
module dtie_pack (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     advance,
   input  wire logic                     in_valid,
   input  wire dtie_pkg::align_type      in_data,
   output logic                          out_valid,
   output logic [63:0]                   out_bits
);

   logic        valid_ff;
   logic [63:0] bits_ff, bits_in;
   logic [63:0] sign_pos, exp_ones, mant;
   logic [5:0]  mbits, tbits;
   logic [63:0] m64;

   always_comb begin
      case (in_data.fmt)
         dtie_pkg::FMT_HALF: begin
            mbits = 6'd10; tbits = 6'd15; exp_ones = 64'h0000_0000_0000_7C00;
         end
         dtie_pkg::FMT_DOUBLE: begin
            mbits = 6'd52; tbits = 6'd63; exp_ones = 64'h7FF0_0000_0000_0000;
         end
         default: begin
            mbits = 6'd23; tbits = 6'd31; exp_ones = 64'h0000_0000_7F80_0000;
         end
      endcase
      sign_pos = 64'(in_data.sign) << tbits;
      m64 = {11'd0, in_data.sig};
      if (in_data.unf) begin
         mant = in_data.shift[6] ? 64'd0 : (m64 >> in_data.shift[5:0]);
      end else begin
         mant = {12'd0, in_data.sig[51:0]} >> (6'd52 - mbits);
      end
      case (in_data.cls)
         dtie_pkg::CLS_NAN:  bits_in = exp_ones | 64'd1;
         dtie_pkg::CLS_INF:  bits_in = sign_pos | exp_ones;
         dtie_pkg::CLS_ZERO: bits_in = sign_pos;
         default: begin
            if (in_data.ovf) begin
               bits_in = sign_pos | exp_ones;
            end else if (in_data.unf) begin
               bits_in = sign_pos | mant;
            end else begin
               bits_in = sign_pos | ({52'd0, in_data.biased} << mbits) | mant;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         bits_ff <= bits_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_bits  = bits_ff;

endmodule : dtie_pack
`default_nettype wire

// File: hdl/double_to_ieee_format_encoder_unit.sv
// Top level of the double to IEEE half/single/double format encoder.
// Usage:
//   req_valid/req_stall/req_value_bits carry one binary64 pattern per item.
//   rsp_valid/rsp_stall/rsp_result_bits return the re-encoded pattern,
//   right-aligned with zero upper bits, one result per item, in order.
//   csr_write_enable/csr_write_data set the target format (0 half,
//   1 single, 2 double, 3 single); write only while the block is idle.
// Pipeline: three register stages (classify, align, pack) between
//   acceptance and rsp_valid; up to three items in flight.
// Throughput: one item per cycle while the output is not stalled.
// Reset: synchronous, clears all stage valid bits and sets the format
//   to single.
// Stall: when rsp_stall is high and the output stage is full, it and
//   the full stages right before it hold; req_stall rises if all are
//   full. Nothing is lost or repeated; empty stages still fill.
`default_nettype none
module double_to_ieee_format_encoder_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [63:0] req_value_bits,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [63:0]      rsp_result_bits,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_write_data
);

   logic [1:0]          fmt_ff;
   logic                v1, v2, v3;
   logic                adv1, adv2, adv3;
   dtie_pkg::norm_type  d1;
   dtie_pkg::align_type d2;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= dtie_pkg::FMT_SINGLE;
      end else if (csr_write_enable) begin
         fmt_ff <= csr_write_data;
      end
   end

   assign adv3 = !v3 || !rsp_stall;
   assign adv2 = adv3 || !v2;
   assign adv1 = adv2 || !v1;
   assign req_stall = !adv1;

   dtie_classify u_classify (
      .clock(clock), .reset(reset), .advance(adv1), .in_valid(req_valid),
      .in_bits(req_value_bits), .fmt(fmt_ff), .out_valid(v1), .out_data(d1)
   );

   dtie_align u_align (
      .clock(clock), .reset(reset), .advance(adv2), .in_valid(v1),
      .in_data(d1), .out_valid(v2), .out_data(d2)
   );

   dtie_pack u_pack (
      .clock(clock), .reset(reset), .advance(adv3), .in_valid(v2),
      .in_data(d2), .out_valid(v3), .out_bits(rsp_result_bits)
   );

   assign rsp_valid = v3;

endmodule : double_to_ieee_format_encoder_unit
`default_nettype wire
